/* hw/rtl/nta_pkg.sv */
// Shared types and constants of the nearest track id assigner.
package nta_pkg;

  // Register indexes on the configuration port
  localparam int unsigned REG_MATCH_RADIUS = 0;
  localparam int unsigned REG_COUNT        = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } nta_state_e;

  // Result flags, is_new in the lowest bit
  typedef struct packed {
    logic table_full;
    logic is_new;
  } nta_flags_t;

endpackage

/* hw/rtl/nta_track_mem.sv */
// Track table: single write port, single read port, registered read data.
module nta_track_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 48,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/nta_ctrl.sv */
// Scan sequencer: walks the track table, keeps the nearest entry, writes back and
// holds the result register.
module nta_ctrl #(
  parameter int unsigned MAX_TRACKS = 64,
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned AW         = 6,
  parameter int unsigned IW         = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [4*COORD_BITS-1:0]   in_rect_i,
  input  logic [2*COORD_BITS-1:0]   radius_sq_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [IW-1:0]             out_id_o,
  output nta_pkg::nta_flags_t       out_flags_o,
  output logic                      mem_rd_en_o,
  output logic [AW-1:0]             mem_rd_addr_o,
  input  logic [4*COORD_BITS-1:0]   mem_rd_data_i,
  output logic                      mem_wr_en_o,
  output logic [AW-1:0]             mem_wr_addr_o,
  output logic [4*COORD_BITS-1:0]   mem_wr_data_o
);
  import nta_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned SW = 2 * C;
  localparam int unsigned DW = 2 * C + 1;

  nta_state_e state_q, state_d;

  logic [4*C-1:0] rect_q;
  logic [IW-1:0]  count_q;
  logic [IW-1:0]  issue_q;
  logic           v1_q, v2_q;
  logic [AW-1:0]  tag1_q, tag2_q;
  logic [SW-1:0]  sqx_q, sqy_q;
  logic [DW-1:0]  best_q;
  logic [AW-1:0]  best_addr_q;
  logic           found_q;
  logic [IW-1:0]  res_id_q;
  nta_flags_t     res_flags_q;
  logic           out_valid_q;
  logic [IW-1:0]  out_id_q;
  nta_flags_t     out_flags_q;

  logic           accept;
  logic           issue;
  logic           scan_done;
  logic           decide;
  logic           load_out;
  logic           match;
  logic           full;
  logic [C-1:0]   ex, ey, dx, dy;
  logic [DW-1:0]  cand_dist;

  assign ex   = mem_rd_data_i[C-1:0];
  assign ey   = mem_rd_data_i[2*C-1:C];
  assign dx   = (ex >= rect_q[C-1:0])   ? ex - rect_q[C-1:0]   : rect_q[C-1:0] - ex;
  assign dy   = (ey >= rect_q[2*C-1:C]) ? ey - rect_q[2*C-1:C] : rect_q[2*C-1:C] - ey;
  assign cand_dist = DW'(sqx_q) + DW'(sqy_q);

  assign match = found_q && (best_q < DW'(radius_sq_i));
  assign full  = (count_q == IW'(MAX_TRACKS));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    scan_done  = 1'b0;
    decide     = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SCAN: begin
        issue     = (issue_q != count_q);
        scan_done = (issue_q == count_q) && !v1_q && !v2_q;
      end
      ST_DECIDE: decide = 1'b1;
      ST_DONE:   load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  assign mem_rd_en_o   = issue;
  assign mem_rd_addr_o = issue_q[AW-1:0];
  assign mem_wr_en_o   = decide && (match || !full);
  assign mem_wr_addr_o = match ? best_addr_q : count_q[AW-1:0];
  assign mem_wr_data_o = rect_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (accept) begin
        issue_q <= '0;
        found_q <= 1'b0;
      end else if (issue) begin
        issue_q <= issue_q + 1'b1;
      end
      if (v2_q && (!found_q || cand_dist <= best_q)) begin
        found_q <= 1'b1;
      end
      if (decide && !match && !full) begin
        count_q <= count_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: request, distance pipeline, best candidate, result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rect_q <= in_rect_i;
    end
    tag1_q <= issue_q[AW-1:0];
    tag2_q <= tag1_q;
    sqx_q  <= SW'(dx) * SW'(dx);
    sqy_q  <= SW'(dy) * SW'(dy);
    // ties go to the later, higher id
    if (v2_q && (!found_q || cand_dist <= best_q)) begin
      best_q      <= cand_dist;
      best_addr_q <= tag2_q;
    end
    if (decide) begin
      if (match) begin
        res_id_q    <= IW'(best_addr_q) + 1'b1;
        res_flags_q <= '{table_full: 1'b0, is_new: 1'b0};
      end else if (!full) begin
        res_id_q    <= count_q + 1'b1;
        res_flags_q <= '{table_full: 1'b0, is_new: 1'b1};
      end else begin
        res_id_q    <= '0;
        res_flags_q <= '{table_full: 1'b1, is_new: 1'b0};
      end
    end
    if (load_out) begin
      out_id_q    <= res_id_q;
      out_flags_q <= res_flags_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_id_q;
  assign out_flags_o = out_flags_q;

endmodule

/* hw/rtl/nearest_track_id_assigner.sv */
// Nearest track id assigner: the single read port of the track table is read once per
// stored entry for each request, one entry per id in use (at most MAX_TRACKS); the squared
// distances are registered behind the registered read data and then compared with the best
// candidate. One request is worked on at a time; a new one is taken while the previous
// result still waits in the output register. The match radius is written through the APB
// port at byte address 0; its square is registered from the stored radius register.
module nearest_track_id_assigner #(
  parameter int unsigned MAX_TRACKS = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // det_x, det_y, det_w, det_h (COORD_BITS each), zero padded to bytes
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]           s_axis_tdata,
  // track_id, zero padded to bytes
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  output logic [(($clog2(MAX_TRACKS+1)+7)/8)*8-1:0]   m_axis_tdata,
  // is_new, table_full
  output nta_pkg::nta_flags_t                         m_axis_tuser,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [2:0]                                  paddr,
  input  logic [31:0]                                 pwdata,
  output logic [31:0]                                 prdata,
  output logic                                        pready
);
  import nta_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned IW    = $clog2(MAX_TRACKS + 1);
  localparam int unsigned AW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned OUT_W = ((IW + 7) / 8) * 8;

  logic [C-1:0]     match_radius_q;
  logic [2*C-1:0]   radius_sq_q;
  logic             cfg_wr;
  logic [1:0]       reg_idx;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [4*C-1:0]   rd_data, wr_data;
  logic [IW-1:0]    track_id;

  assign pready  = 1'b1;
  assign reg_idx = {1'b0, paddr[2]};
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == 2'(REG_MATCH_RADIUS));
  assign prdata  = (reg_idx == 2'(REG_MATCH_RADIUS)) ? 32'(match_radius_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_radius_q <= '0;
      radius_sq_q    <= '0;
    end else begin
      if (cfg_wr) begin
        match_radius_q <= pwdata[C-1:0];
      end
      radius_sq_q <= (2*C)'(match_radius_q) * (2*C)'(match_radius_q);
    end
  end

  nta_track_mem #(
    .DEPTH (MAX_TRACKS),
    .WIDTH (4 * C),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  nta_ctrl #(
    .MAX_TRACKS (MAX_TRACKS),
    .COORD_BITS (C),
    .AW         (AW),
    .IW         (IW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_rect_i     (s_axis_tdata[4*C-1:0]),
    .radius_sq_i   (radius_sq_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_id_o      (track_id),
    .out_flags_o   (m_axis_tuser),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_rd_data_i (rd_data),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data)
  );

  assign m_axis_tdata = OUT_W'(track_id);

endmodule
